[rtl/sdsf_pkg.sv]
// scanline depth span fill: shared constants, codes and control types
// used by the rtl files of the block other than sdsf_ram; depends on nothing
`default_nettype none

package sdsf_pkg;

  // store geometry
  localparam int MaxWidth = 512;
  localparam int AddrW    = $clog2(MaxWidth);

  // fixed field widths
  localparam int KindW  = 2;
  localparam int ModeW  = 2;
  localparam int LineW  = 10;
  localparam int XW     = 11;
  localparam int DepthW = 16;
  localparam int ColorW = 16;
  localparam int IdxW   = 9;
  localparam int RunW   = 32;

  // signed width for column math, wide enough for the store and for x values
  localparam int CmpW = (($clog2(MaxWidth) + 2) > (XW + 2)) ? ($clog2(MaxWidth) + 2) : (XW + 2);

  // divider step counter
  localparam int DivCntW = $clog2(DepthW);

  // apb port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  // register indexes
  localparam logic RegMode  = 1'b0;
  localparam logic RegWidth = 1'b1;

  // reset values of the registers
  localparam logic [ModeW-1:0] ModeReset  = 2'd0;
  localparam logic [LineW-1:0] WidthReset = 10'd320;

  // item kinds
  localparam logic [KindW-1:0] KindSpan  = 2'd0;
  localparam logic [KindW-1:0] KindRead  = 2'd1;
  localparam logic [KindW-1:0] KindClear = 2'd2;

  // render modes
  localparam logic [ModeW-1:0] ModeDepth = 2'd0;
  localparam logic [ModeW-1:0] ModeFlat  = 2'd1;
  localparam logic [ModeW-1:0] ModeWire  = 2'd2;

  // what the loaded word asks for
  typedef enum logic [2:0] {
    ActNone,
    ActRead,
    ActClear,
    ActDepth,
    ActFlat,
    ActWire
  } act_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic untouch;
    logic span_init;
    logic div_step;
    logic div_fin;
    logic walk_step;
    logic touch;
    logic wire_r;
    logic wire_l;
    logic rd_capture;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_e act;
    logic clr_last;
    logic div_last;
    logic walk_more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/sdsf_in_if.sv]
// input channel of the span fill block: valid/ready plus one item word
// depends on sdsf_pkg
`default_nettype none

interface sdsf_in_if;
  import sdsf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [XW-1:0]     left_x;
  logic signed [XW-1:0]     right_x;
  logic [DepthW-1:0]        left_depth;
  logic [DepthW-1:0]        right_depth;
  logic [ColorW-1:0]        span_color;
  logic [IdxW-1:0]          pixel_index;

  modport source (
    output valid, kind, left_x, right_x, left_depth, right_depth, span_color, pixel_index,
    input  ready
  );

  modport sink (
    input  valid, kind, left_x, right_x, left_depth, right_depth, span_color, pixel_index,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sdsf_out_if.sv]
// output channel of the span fill block: valid/ready plus the read-back color
// depends on sdsf_pkg
`default_nettype none

interface sdsf_out_if;
  import sdsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [ColorW-1:0] pixel_color;

  modport source (
    output valid, pixel_color,
    input  ready
  );

  modport sink (
    input  valid, pixel_color,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sdsf_ram.sv]
// generic simple dual port ram: one write port, one read port, registered read
// no package dependency
`default_nettype none

module sdsf_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/sdsf_ctrl.sv]
// controller of the span fill block: sequences load, clear sweep, division,
// pixel walk, wire end points and read-back; depends on sdsf_pkg
`default_nettype none

module sdsf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sdsf_pkg::stat_t stat_i,
  output sdsf_pkg::cmd_t       cmd_o
);
  import sdsf_pkg::*;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StDecode,
    StDiv,
    StFin,
    StWalk,
    StWireR,
    StWireL,
    StRead
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        unique case (stat_i.act)
          ActRead: begin
            state_d = StRead;
          end
          ActClear: begin
            cmd_o.untouch = 1'b1;
            state_d       = StClear;
          end
          ActDepth: begin
            cmd_o.span_init = 1'b1;
            state_d         = StDiv;
          end
          ActFlat: begin
            cmd_o.span_init = 1'b1;
            state_d         = StWalk;
          end
          ActWire: begin
            state_d = StWireR;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.div_fin = 1'b1;
        state_d       = StWalk;
      end
      StWalk: begin
        if (stat_i.walk_more) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.touch = 1'b1;
          state_d     = StIdle;
        end
      end
      StWireR: begin
        cmd_o.wire_r = 1'b1;
        state_d      = StWireL;
      end
      StWireL: begin
        cmd_o.wire_l = 1'b1;
        state_d      = StIdle;
      end
      StRead: begin
        if (stat_i.out_free) begin
          cmd_o.rd_capture = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/sdsf_datapath.sv]
// datapath of the span fill block: item registers, span decode, serial
// divider, pixel walk pipeline, color and depth rams, output register
// depends on sdsf_pkg and sdsf_ram
`default_nettype none

module sdsf_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sdsf_pkg::cmd_t                  cmd_i,
  output sdsf_pkg::stat_t                      stat_o,
  input  wire logic [sdsf_pkg::ModeW-1:0]      mode_i,
  input  wire logic [sdsf_pkg::LineW-1:0]      line_width_i,
  input  wire logic [sdsf_pkg::KindW-1:0]      kind_i,
  input  wire logic signed [sdsf_pkg::XW-1:0]  left_x_i,
  input  wire logic signed [sdsf_pkg::XW-1:0]  right_x_i,
  input  wire logic [sdsf_pkg::DepthW-1:0]     left_depth_i,
  input  wire logic [sdsf_pkg::DepthW-1:0]     right_depth_i,
  input  wire logic [sdsf_pkg::ColorW-1:0]     span_color_i,
  input  wire logic [sdsf_pkg::IdxW-1:0]       pixel_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [sdsf_pkg::ColorW-1:0]          pixel_color_o
);
  import sdsf_pkg::*;

  localparam logic signed [CmpW-1:0] MaxW = CmpW'(MaxWidth);
  localparam logic signed [CmpW-1:0] OneC = CmpW'(1);
  localparam logic [CmpW-1:0]        MaxU = CmpW'(MaxWidth);

  // item word registers
  logic [KindW-1:0]      kind_q;
  logic signed [XW-1:0]  lx_q, rx_q;
  logic [DepthW-1:0]     ld_q, rd_q;
  logic [ColorW-1:0]     col_q;
  logic [IdxW-1:0]       idx_q;

  // span geometry
  logic signed [CmpW-1:0] lx_s, rx_s, lw_s, w_s, end_s, div_s, dneg_s;
  logic signed [DepthW:0] diff_s, diffneg_s;
  logic [DepthW-1:0]      amag;
  logic [CmpW-1:0]        dmag;
  logic [CmpW-1:0]        idx_ext;
  logic                   lx_pos, rx_in, oob;
  act_e                   act;

  // divider
  logic [CmpW-1:0]    rem_q, rem_d;
  logic [DepthW-1:0]  quo_q, quo_d, quo_neg, q16;
  logic [CmpW-1:0]    dmag_q;
  logic               neg_q, dzero_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [CmpW:0]      rsh, dext, rdiff;
  logic               ge;

  // walk
  logic signed [CmpW-1:0] x_q, end_q;
  logic [RunW-1:0]        run_q, step_q;
  logic                   s_valid_q;
  logic [AddrW-1:0]       s_addr_q;
  logic [RunW-1:0]        s_run_q;
  logic                   pass;

  // misc state
  logic [AddrW-1:0]  clr_q;
  logic              clr_last;
  logic              touched_q;
  logic              out_valid_q;
  logic [ColorW-1:0] pix_q;

  // ram ports
  logic              c_we, d_we;
  logic [AddrW-1:0]  c_waddr, d_waddr, c_raddr, d_raddr;
  logic [ColorW-1:0] c_wdata, c_rdata;
  logic [DepthW-1:0] d_wdata, d_rdata;

  // item word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      lx_q   <= left_x_i;
      rx_q   <= right_x_i;
      ld_q   <= left_depth_i;
      rd_q   <= right_depth_i;
      col_q  <= span_color_i;
      idx_q  <= pixel_index_i;
    end
  end

  // span geometry: usable width, clamped end, divisor and depth delta
  always_comb begin
    lx_s      = {{(CmpW-XW){lx_q[XW-1]}}, lx_q};
    rx_s      = {{(CmpW-XW){rx_q[XW-1]}}, rx_q};
    lw_s      = {{(CmpW-LineW){1'b0}}, line_width_i};
    w_s       = (lw_s > MaxW) ? MaxW : lw_s;
    end_s     = (rx_s >= w_s) ? w_s : rx_s;
    div_s     = end_s - lx_s + OneC;
    dneg_s    = -div_s;
    dmag      = div_s[CmpW-1] ? dneg_s : div_s;
    diff_s    = {1'b0, rd_q} - {1'b0, ld_q};
    diffneg_s = -diff_s;
    amag      = diff_s[DepthW] ? diffneg_s[DepthW-1:0] : diff_s[DepthW-1:0];
    lx_pos    = !lx_s[CmpW-1] && (lx_s != '0);
    rx_in     = rx_s < w_s;
    idx_ext   = {{(CmpW-IdxW){1'b0}}, idx_q};
    oob       = idx_ext >= MaxU;
  end

  // decode what the loaded word asks for
  always_comb begin
    act = ActNone;
    unique case (kind_q)
      KindSpan: begin
        unique case (mode_i)
          ModeDepth: act = lx_pos ? ActDepth : ActNone;
          ModeFlat:  act = (lx_pos && rx_in) ? ActFlat : ActNone;
          ModeWire:  act = (lx_pos && rx_in) ? ActWire : ActNone;
          default:   act = ActNone;
        endcase
      end
      KindRead:  act = ActRead;
      KindClear: act = ActClear;
      default:   act = ActNone;
    endcase
  end

  // one restoring division step on the magnitudes
  always_comb begin
    rsh     = {rem_q, quo_q[DepthW-1]};
    dext    = {1'b0, dmag_q};
    ge      = rsh >= dext;
    rdiff   = rsh - dext;
    rem_d   = ge ? rdiff[CmpW-1:0] : rsh[CmpW-1:0];
    quo_d   = {quo_q[DepthW-2:0], ge};
    quo_neg = -quo_q;
    q16     = dzero_q ? '0 : (neg_q ? quo_neg : quo_q);
  end

  // divider registers and walk setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.span_init) begin
      rem_q   <= '0;
      quo_q   <= amag;
      dmag_q  <= dmag;
      neg_q   <= diff_s[DepthW] ^ div_s[CmpW-1];
      dzero_q <= (div_s == '0);
      x_q     <= lx_s;
      end_q   <= end_s;
      run_q   <= {{(RunW-DepthW){1'b0}}, ld_q};
    end else begin
      if (cmd_i.div_step) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      if (cmd_i.div_fin) begin
        step_q <= {{(RunW-DepthW){q16[DepthW-1]}}, q16};
      end
      if (cmd_i.walk_step) begin
        x_q   <= x_q + OneC;
        run_q <= run_q + step_q;
      end
    end
  end

  // division step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.span_init) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DivCntW'(1);
    end
  end

  // walk stage: depth read issued on a walk step, test and write in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= cmd_i.walk_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      s_addr_q <= x_q[AddrW-1:0];
      s_run_q  <= run_q;
    end
  end

  // the first span after a clear or reset, and every flat span, write without the depth test
  assign pass = !((act == ActDepth) && touched_q)
             || ({{(RunW-DepthW){1'b0}}, d_rdata} > s_run_q);

  // clearing sweep counter
  assign clr_last = (clr_q == AddrW'(MaxWidth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_last ? '0 : clr_q + AddrW'(1);
    end
  end

  // line touched flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= 1'b0;
    end else if (cmd_i.untouch) begin
      touched_q <= 1'b0;
    end else if (cmd_i.touch) begin
      touched_q <= 1'b1;
    end
  end

  // ram port selection
  always_comb begin
    c_we    = 1'b0;
    c_waddr = s_addr_q;
    c_wdata = col_q;
    d_we    = 1'b0;
    d_waddr = s_addr_q;
    d_wdata = s_run_q[DepthW-1:0];
    c_raddr = AddrW'(idx_q);
    d_raddr = x_q[AddrW-1:0];
    if (cmd_i.clr_step) begin
      c_we    = 1'b1;
      c_waddr = clr_q;
      c_wdata = '0;
      d_we    = 1'b1;
      d_waddr = clr_q;
      d_wdata = '1;
    end else if (s_valid_q) begin
      c_we = pass;
      d_we = pass && (act == ActDepth);
    end else if (cmd_i.wire_r) begin
      c_we    = !rx_s[CmpW-1];
      c_waddr = rx_s[AddrW-1:0];
    end else if (cmd_i.wire_l) begin
      c_we    = lx_s < w_s;
      c_waddr = lx_s[AddrW-1:0];
    end
  end

  sdsf_ram #(
    .Width (ColorW),
    .Depth (MaxWidth)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  sdsf_ram #(
    .Width (DepthW),
    .Depth (MaxWidth)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_capture) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_capture) begin
      pix_q <= oob ? '0 : c_rdata;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = pix_q;

  // status to the controller
  always_comb begin
    stat_o.act       = act;
    stat_o.clr_last  = clr_last;
    stat_o.div_last  = (dcnt_q == DivCntW'(DepthW - 1));
    stat_o.walk_more = x_q < end_q;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

[rtl/scanline_depth_span_fill.sv]
// scanline depth span fill, top level: apb registers, controller, datapath
// depends on sdsf_pkg, sdsf_in_if, sdsf_out_if, sdsf_ctrl, sdsf_datapath
//
// Usage: req_i takes one word per accepted valid/ready handshake: a span,
// a pixel read or a line clear. rsp_o returns one word for each read.
// render_mode sits at byte address 0 and line_width at 4 on the apb port,
// written by the user only while the block is idle, which the block itself
// does not enforce. Steps per word, from acceptance to the next ready:
//   depth span: a serial divider forms the depth step, then one pixel per
//   cycle through the depth ram read/compare/write
//   flat span: the pixel walk alone; wire span: right then left end point;
//   skipped span: decode only; read: waits until rsp_o is free, then loads it
//   clear: one store entry per cycle over all 512 columns
// After reset the block sweeps all 512 columns of both stores with req_i.ready
// low; register writes are taken meanwhile. A stalled rsp_o holds its word
// in the output register; the block keeps taking spans and clears, and a
// following read waits until the register is free.
`default_nettype none

module scanline_depth_span_fill (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sdsf_in_if.sink                            req_i,
  sdsf_out_if.source                         rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sdsf_pkg::PaddrW-1:0]   paddr,
  input  wire logic [sdsf_pkg::PdataW-1:0]   pwdata,
  output logic      [sdsf_pkg::PdataW-1:0]   prdata,
  output logic                               pready
);
  import sdsf_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic [LineW-1:0] width_q;
  logic             reg_idx;
  logic             wr_en;
  logic             in_ready;
  cmd_t             cmd;
  stat_t            stat;

  // apb register access
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeReset;
      width_q <= WidthReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMode:  mode_q  <= pwdata[ModeW-1:0];
        RegWidth: width_q <= pwdata[LineW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegMode:  prdata = {{(PdataW-ModeW){1'b0}}, mode_q};
      RegWidth: prdata = {{(PdataW-LineW){1'b0}}, width_q};
      default:  prdata = '0;
    endcase
  end

  assign req_i.ready = in_ready;

  sdsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sdsf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_q),
    .line_width_i  (width_q),
    .kind_i        (req_i.kind),
    .left_x_i      (req_i.left_x),
    .right_x_i     (req_i.right_x),
    .left_depth_i  (req_i.left_depth),
    .right_depth_i (req_i.right_depth),
    .span_color_i  (req_i.span_color),
    .pixel_index_i (req_i.pixel_index),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .pixel_color_o (rsp_o.pixel_color)
  );

endmodule

`default_nettype wire
